// File: rtl/swrm_pkg.sv
package swrm_pkg;

	localparam int TIME_W      = 32;
	localparam int BYTES_W     = 64;
	localparam int SCALE_W     = 10;
	localparam int SCALED_W    = BYTES_W + SCALE_W;
	localparam int QUEUE_DEPTH = 2;

	// one classified sample handed from the front end to the back end
	typedef struct packed {
		logic               live;
		logic [BYTES_W-1:0] in_delta;
		logic [BYTES_W-1:0] out_delta;
		logic [TIME_W-1:0]  entry_begin;
		logic [TIME_W-1:0]  now;
	} req_t;

endpackage

// File: rtl/swrm_front.sv
module swrm_front import swrm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [TIME_W-1:0]  time_ms,
	input  logic [BYTES_W-1:0] total_in_bytes,
	input  logic [BYTES_W-1:0] total_out_bytes,
	input  logic               q_full,
	output logic               q_push,
	output req_t               q_req
);

	logic [TIME_W-1:0]  last_time_q;
	logic [BYTES_W-1:0] prev_in_q;
	logic [BYTES_W-1:0] prev_out_q;
	logic [TIME_W-1:0]  elapsed;
	logic               live;

	assign elapsed = time_ms - last_time_q;
	// zero or backward steps in time are dropped
	assign live    = (elapsed != '0) && !elapsed[TIME_W-1];
	assign q_push  = push && !q_full;

	always_comb begin
		q_req.live        = live;
		q_req.in_delta    = total_in_bytes - prev_in_q;
		q_req.out_delta   = total_out_bytes - prev_out_q;
		q_req.entry_begin = last_time_q;
		q_req.now         = time_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			prev_in_q   <= '0;
			prev_out_q  <= '0;
		end else if (q_push && live) begin
			last_time_q <= time_ms;
			prev_in_q   <= total_in_bytes;
			prev_out_q  <= total_out_bytes;
		end
	end

endmodule

// File: rtl/swrm_fifo.sv
module swrm_fifo import swrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	output logic full,
	input  logic pop,
	output logic empty,
	output req_t pop_req
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	req_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = count_q == CNT_W'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign pop_req = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slots_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop_ok && !push_ok) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

// File: rtl/swrm_div.sv
module swrm_div import swrm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SCALED_W-1:0] dividend,
	input  logic [TIME_W-1:0]   divisor,
	output logic                busy,
	output logic [BYTES_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(SCALED_W + 1);

	logic [SCALED_W-1:0] dq_q;
	logic [TIME_W-1:0]   rem_q;
	logic [TIME_W-1:0]   div_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TIME_W:0]     trial;
	logic                fits;
	logic [TIME_W-1:0]   rem_next;

	assign trial    = {rem_q, dq_q[SCALED_W-1]};
	assign fits     = trial >= {1'b0, div_q};
	assign rem_next = fits ? TIME_W'(trial - {1'b0, div_q}) : trial[TIME_W-1:0];
	assign busy     = cnt_q != '0;
	// saturate when the quotient needs more than 64 bits
	assign quotient = (|dq_q[SCALED_W-1:BYTES_W]) ? '1 : dq_q[BYTES_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy) begin
			dq_q  <= {dq_q[SCALED_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(SCALED_W);
		end else if (busy) begin
			cnt_q <= CNT_W'(cnt_q - 1'b1);
		end
	end

endmodule

// File: rtl/swrm_back.sv
module swrm_back import swrm_pkg::*; #(
	parameter int WINDOW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  req_t               q_req,
	output logic               empty,
	input  logic               pop,
	output logic [BYTES_W-1:0] in_rate,
	output logic [BYTES_W-1:0] sent_rate,
	output logic               updated
);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_START,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [WINDOW-1:0]   ring_valid_q;
	logic [TIME_W-1:0]   now_q;
	logic [BYTES_W-1:0]  in_sum_q;
	logic [BYTES_W-1:0]  out_sum_q;
	logic [TIME_W-1:0]   span_q;
	logic [BYTES_W-1:0]  held_in_q;
	logic [BYTES_W-1:0]  held_out_q;
	logic                out_valid_q;
	logic [BYTES_W-1:0]  in_rate_q;
	logic [BYTES_W-1:0]  sent_rate_q;
	logic                updated_q;

	logic [BYTES_W-1:0]  ring_in_mem    [WINDOW];
	logic [BYTES_W-1:0]  ring_out_mem   [WINDOW];
	logic [TIME_W-1:0]   ring_start_mem [WINDOW];
	logic [BYTES_W-1:0]  rd_in_s1;
	logic [BYTES_W-1:0]  rd_out_s1;
	logic [TIME_W-1:0]   rd_start_s1;
	logic                rd_live_s1;

	logic                out_free;
	logic                post_rates;
	logic                ring_wr;
	logic [TIME_W-1:0]   rd_age;
	logic [SCALED_W-1:0] scaled_in;
	logic [SCALED_W-1:0] scaled_out;
	logic                div_start;
	logic                div_in_busy;
	logic                div_out_busy;
	logic                div_busy;
	logic [BYTES_W-1:0]  quot_in;
	logic [BYTES_W-1:0]  quot_out;

	assign out_free   = !out_valid_q || pop;
	assign q_pop      = (state_q == ST_IDLE) && !q_empty && (q_req.live || out_free);
	assign ring_wr    = q_pop && q_req.live;
	assign post_rates = (q_pop && !q_req.live) || ((state_q == ST_FINISH) && out_free);
	assign rd_age     = now_q - rd_start_s1;
	assign div_start  = state_q == ST_START;
	assign div_busy   = div_in_busy || div_out_busy;

	// x1000 as x1024 - x16 - x8
	assign scaled_in  = {in_sum_q, 10'b0} - {6'b0, in_sum_q, 4'b0} - {7'b0, in_sum_q, 3'b0};
	assign scaled_out = {out_sum_q, 10'b0} - {6'b0, out_sum_q, 4'b0} - {7'b0, out_sum_q, 3'b0};

	assign empty     = !out_valid_q;
	assign in_rate   = in_rate_q;
	assign sent_rate = sent_rate_q;
	assign updated   = updated_q;

	swrm_div u_div_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (scaled_in),
		.divisor  (span_q),
		.busy     (div_in_busy),
		.quotient (quot_in)
	);

	swrm_div u_div_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (scaled_out),
		.divisor  (span_q),
		.busy     (div_out_busy),
		.quotient (quot_out)
	);

	always_ff @(posedge clk) begin
		if (ring_wr) begin
			ring_in_mem[slot_q]    <= q_req.in_delta;
			ring_out_mem[slot_q]   <= q_req.out_delta;
			ring_start_mem[slot_q] <= q_req.entry_begin;
		end
		rd_in_s1    <= ring_in_mem[idx_q];
		rd_out_s1   <= ring_out_mem[idx_q];
		rd_start_s1 <= ring_start_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_q       <= '0;
			idx_q        <= '0;
			ring_valid_q <= '0;
			now_q        <= '0;
			in_sum_q     <= '0;
			out_sum_q    <= '0;
			span_q       <= '0;
			held_in_q    <= '0;
			held_out_q   <= '0;
			rd_live_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
			in_rate_q    <= '0;
			sent_rate_q  <= '0;
			updated_q    <= 1'b0;
		end else begin
			if (post_rates) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			rd_live_s1 <= (state_q == ST_SCAN) && ring_valid_q[idx_q];
			if (rd_live_s1) begin
				in_sum_q  <= in_sum_q + rd_in_s1;
				out_sum_q <= out_sum_q + rd_out_s1;
				if (rd_age > span_q) begin
					span_q <= rd_age;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_req.live) begin
						ring_valid_q[slot_q] <= 1'b1;
						slot_q    <= (slot_q == LAST_SLOT) ? '0 : SLOT_W'(slot_q + 1'b1);
						now_q     <= q_req.now;
						in_sum_q  <= '0;
						out_sum_q <= '0;
						span_q    <= '0;
						idx_q     <= '0;
						state_q   <= ST_SCAN;
					end else if (q_pop) begin
						in_rate_q   <= held_in_q;
						sent_rate_q <= held_out_q;
						updated_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_SLOT) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= SLOT_W'(idx_q + 1'b1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (!div_busy) begin
						held_in_q  <= quot_in;
						held_out_q <= quot_out;
						state_q    <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						in_rate_q   <= held_in_q;
						sent_rate_q <= held_out_q;
						updated_q   <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_scan_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> ring_valid_q != '0)
		else $error("window scan with no valid entry");

	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> span_q != '0)
		else $error("division by a zero window span");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_START |=> div_busy)
		else $error("dividers did not start");

	a_finish_posts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && out_free |=> out_valid_q && updated_q)
		else $error("recomputed rates not posted");

endmodule

// File: rtl/sliding_window_rate_meter_unit.sv
// Sliding-window throughput meter. Each request carries a millisecond timestamp and the
// cumulative received and sent byte totals, and produces exactly one result in order:
// the received and sent rates in bytes per second over the last WINDOW accepted samples,
// truncated and saturated at 64 bits, plus updated, which is low when the sample was dropped
// because its time did not move forward (the held rates are then repeated). The front end
// classifies a request and forms the byte deltas in the cycle it is taken, then parks it in a
// two-entry queue, so push is refused only while that queue is full. A dropped sample leaves
// the back end straight from the queue head once the back end is idle and its output is free.
// An accepted sample is handled in the back end in steps: a pass over every ring entry sums
// the deltas and finds the oldest start time through the ring's single read port, then the two
// bit-serial dividers run side by side on sum*1000 / span. No clearing pass is needed after
// reset; ring entries carry valid bits.
module sliding_window_rate_meter_unit import swrm_pkg::*; #(
	parameter int WINDOW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [TIME_W-1:0]  time_ms,
	input  logic [BYTES_W-1:0] total_in_bytes,
	input  logic [BYTES_W-1:0] total_out_bytes,
	output logic               empty,
	input  logic               pop,
	output logic [BYTES_W-1:0] in_rate,
	output logic [BYTES_W-1:0] sent_rate,
	output logic               updated
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	req_t push_req;
	req_t pop_req;

	assign full = q_full;

	swrm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.time_ms         (time_ms),
		.total_in_bytes  (total_in_bytes),
		.total_out_bytes (total_out_bytes),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_req           (push_req)
	);

	swrm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_req (push_req),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_req  (pop_req)
	);

	swrm_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_req     (pop_req),
		.empty     (empty),
		.pop       (pop),
		.in_rate   (in_rate),
		.sent_rate (sent_rate),
		.updated   (updated)
	);

endmodule
